>>> sv/itbl_pkg.sv
// ----------------------------------------------------------------------------
// itbl_pkg
// Shared types, operation codes and default sizes of the interval table engine.
// ----------------------------------------------------------------------------
package itbl_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int ENERGY_BITS_DEF = 32;

  localparam int KIND_W   = 3;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int FIDX_W   = 4;
  localparam int COUNT_W  = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_MERGE  = 3'd2,
    KIND_REMOVE = 3'd3,
    KIND_LOOKUP = 3'd4,
    KIND_RANGE  = 3'd5,
    KIND_READ   = 3'd6,
    KIND_CLEAR  = 3'd7
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_ORDER   = 2'd1,
    ST_FULL    = 2'd2,
    ST_BAD_POS = 2'd3
  } status_t;

endpackage

>>> sv/itbl_if.sv
// ----------------------------------------------------------------------------
// itbl_in_if / itbl_out_if
// Valid/ready channels that carry the operation items and the result items.
// ----------------------------------------------------------------------------
interface itbl_in_if #(
  parameter int EW = itbl_pkg::ENERGY_BITS_DEF
) ();
  import itbl_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [EW-1:0]     low_energy;
  logic [EW-1:0]     high_energy;
  logic [POS_W-1:0]  position;
  logic [EW-1:0]     probe_energy;

  modport source (output valid, kind, low_energy, high_energy, position, probe_energy,
                  input ready);
  modport sink   (input valid, kind, low_energy, high_energy, position, probe_energy,
                  output ready);
endinterface

interface itbl_out_if #(
  parameter int EW = itbl_pkg::ENERGY_BITS_DEF
) ();
  import itbl_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [FIDX_W-1:0]   found_index;
  logic                inside_any;
  logic                range_covered;
  logic [EW-1:0]       entry_low;
  logic [EW-1:0]       entry_high;
  logic [COUNT_W-1:0]  entry_count;
  logic [EW-1:0]       overall_low;
  logic [EW-1:0]       overall_high;

  modport source (output valid, status, found, found_index, inside_any, range_covered,
                  entry_low, entry_high, entry_count, overall_low, overall_high,
                  input ready);
  modport sink   (input valid, status, found, found_index, inside_any, range_covered,
                  entry_low, entry_high, entry_count, overall_low, overall_high,
                  output ready);
endinterface

>>> sv/interval_table_engine_top.sv
// ----------------------------------------------------------------------------
// interval_table_engine_top
// A table of up to DEPTH (low, high) intervals, handled one entry per step by
// a small sequencer around a single-port-read table memory.
// ----------------------------------------------------------------------------
// Each item is one table operation, and the block takes no new item until the
// current one is finished. Every entry visit is a read state followed by a
// state that uses the data, because the table memory has one registered read
// port: a read is issued and the data is used in the next cycle. The overall
// low and high bounds are rebuilt by a scan of the table after every append,
// insert, merge or remove, and a clear sets them to zero. The finished result
// sits in an output register, so the next item can be taken while the result
// waits.
// ----------------------------------------------------------------------------
module interval_table_engine_top #(
  parameter int DEPTH       = itbl_pkg::DEPTH_DEF,
  parameter int ENERGY_BITS = itbl_pkg::ENERGY_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  itbl_in_if.sink     in_ch,
  itbl_out_if.source  out_ch
);
  import itbl_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = CNT_W + POS_W;
  localparam int EW    = ENERGY_BITS;

  // Sequencer states. Each "_RD" state issues a memory read; the matching
  // "_EV" or "_WR" state consumes the registered read data.
  typedef enum logic [16:0] {
    S_IDLE    = 17'h00001,
    S_SLOT_RD = 17'h00002,
    S_SLOT_EV = 17'h00004,
    S_SHUP_RD = 17'h00008,
    S_SHUP_WR = 17'h00010,
    S_PLACE   = 17'h00020,
    S_MRG_RD  = 17'h00040,
    S_MRG_EV  = 17'h00080,
    S_MRG_END = 17'h00100,
    S_DROP_RD = 17'h00200,
    S_DROP_WR = 17'h00400,
    S_OVR_RD  = 17'h00800,
    S_OVR_EV  = 17'h01000,
    S_LKP_RD  = 17'h02000,
    S_LKP_EV  = 17'h04000,
    S_GET_EV  = 17'h08000,
    S_DONE    = 17'h10000
  } state_t;

  state_t             state_r, state_nxt;
  kind_t              kind_r, kind_nxt;
  logic [EW-1:0]      lo_r, lo_nxt, hi_r, hi_nxt, probe_r, probe_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt, slot_r, slot_nxt, wp_r, wp_nxt, cnt_r, cnt_nxt;
  logic [EW-1:0]      cur_lo_r, cur_lo_nxt, cur_hi_r, cur_hi_nxt;
  logic [EW-1:0]      min_r, min_nxt, max_r, max_nxt;
  status_t            status_r, status_nxt;
  logic               found_r, found_nxt, inside_r, inside_nxt, cov_r, cov_nxt;
  logic [IDX_W-1:0]   fidx_r, fidx_nxt;
  logic [EW-1:0]      elo_r, elo_nxt, ehi_r, ehi_nxt;

  // Result register toward the output channel.
  logic               ov_r;
  logic               out_load;
  status_t            o_status_r;
  logic               o_found_r, o_inside_r, o_cov_r;
  logic [FIDX_W-1:0]  o_fidx_r;
  logic [EW-1:0]      o_elo_r, o_ehi_r, o_min_r, o_max_r;
  logic [COUNT_W-1:0] o_cnt_r;

  // Table memory: one write and one registered read per cycle.
  logic [EW-1:0]      lo_mem [DEPTH];
  logic [EW-1:0]      hi_mem [DEPTH];
  logic [IDX_W-1:0]   rd_addr, wr_addr;
  logic               wr_en;
  logic [EW-1:0]      wr_lo, wr_hi, rd_lo_r, rd_hi_r;

  logic               in_acc;
  logic [CNT_W-1:0]   idx_inc, idx_dec;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign idx_inc  = idx_r + CNT_W'(1);
  assign idx_dec  = idx_r - CNT_W'(1);
  assign out_load = (state_r == S_DONE) && (!ov_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lo_mem[wr_addr] <= wr_lo;
      hi_mem[wr_addr] <= wr_hi;
    end
    rd_lo_r <= lo_mem[rd_addr];
    rd_hi_r <= hi_mem[rd_addr];
  end

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    probe_nxt  = probe_r;
    idx_nxt    = idx_r;
    slot_nxt   = slot_r;
    wp_nxt     = wp_r;
    cnt_nxt    = cnt_r;
    cur_lo_nxt = cur_lo_r;
    cur_hi_nxt = cur_hi_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    fidx_nxt   = fidx_r;
    inside_nxt = inside_r;
    cov_nxt    = cov_r;
    elo_nxt    = elo_r;
    ehi_nxt    = ehi_r;
    rd_addr    = idx_r[IDX_W-1:0];
    wr_en      = 1'b0;
    wr_addr    = idx_r[IDX_W-1:0];
    wr_lo      = rd_lo_r;
    wr_hi      = rd_hi_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt   = kind_t'(in_ch.kind);
          lo_nxt     = in_ch.low_energy;
          hi_nxt     = in_ch.high_energy;
          probe_nxt  = in_ch.probe_energy;
          status_nxt = ST_OK;
          found_nxt  = 1'b0;
          fidx_nxt   = '0;
          inside_nxt = 1'b0;
          cov_nxt    = 1'b0;
          elo_nxt    = '0;
          ehi_nxt    = '0;
          idx_nxt    = '0;
          unique case (kind_t'(in_ch.kind))
            KIND_APPEND, KIND_INSERT, KIND_MERGE: begin
              if (in_ch.low_energy > in_ch.high_energy) begin
                status_nxt = ST_ORDER;
                state_nxt  = S_DONE;
              end else if (cnt_r >= CNT_W'(DEPTH)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else if (kind_t'(in_ch.kind) == KIND_APPEND) begin
                slot_nxt  = cnt_r;
                idx_nxt   = cnt_r;
                state_nxt = S_SHUP_RD;
              end else begin
                state_nxt = S_SLOT_RD;
              end
            end
            KIND_REMOVE, KIND_READ: begin
              if (CMP_W'(in_ch.position) >= CMP_W'(cnt_r)) begin
                status_nxt = ST_BAD_POS;
                state_nxt  = S_DONE;
              end else if (kind_t'(in_ch.kind) == KIND_REMOVE) begin
                idx_nxt   = CNT_W'(in_ch.position) + CNT_W'(1);
                state_nxt = S_DROP_RD;
              end else begin
                idx_nxt   = CNT_W'(in_ch.position);
                state_nxt = S_GET_EV;
              end
            end
            KIND_LOOKUP: state_nxt = S_LKP_RD;
            KIND_RANGE: begin
              cov_nxt   = (in_ch.low_energy >= min_r) && (in_ch.high_energy <= max_r);
              state_nxt = S_DONE;
            end
            KIND_CLEAR: begin
              cnt_nxt   = '0;
              min_nxt   = '0;
              max_nxt   = '0;
              state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      // Find the first entry whose low bound is above the new one.
      S_SLOT_RD: begin
        if (idx_r == cnt_r) begin
          slot_nxt  = cnt_r;
          idx_nxt   = cnt_r;
          state_nxt = S_SHUP_RD;
        end else begin
          state_nxt = S_SLOT_EV;
        end
      end
      S_SLOT_EV: begin
        if (lo_r < rd_lo_r) begin
          slot_nxt  = idx_r;
          idx_nxt   = cnt_r;
          state_nxt = S_SHUP_RD;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SLOT_RD;
        end
      end

      // Open a hole at the slot, moving entries up from the top.
      S_SHUP_RD: begin
        rd_addr = idx_dec[IDX_W-1:0];
        if (idx_r == slot_r) begin
          state_nxt = S_PLACE;
        end else begin
          state_nxt = S_SHUP_WR;
        end
      end
      S_SHUP_WR: begin
        wr_en     = 1'b1;
        idx_nxt   = idx_dec;
        state_nxt = S_SHUP_RD;
      end
      S_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = slot_r[IDX_W-1:0];
        wr_lo   = lo_r;
        wr_hi   = hi_r;
        cnt_nxt = cnt_r + CNT_W'(1);
        idx_nxt = '0;
        wp_nxt  = '0;
        if (kind_r == KIND_MERGE) begin
          state_nxt = S_MRG_RD;
        end else begin
          state_nxt = S_OVR_RD;
        end
      end

      // Merge pass: walk the entries with a running interval and compact the
      // table in place; the write pointer never passes the read index.
      S_MRG_RD: begin
        if (idx_r == cnt_r) begin
          state_nxt = S_MRG_END;
        end else begin
          state_nxt = S_MRG_EV;
        end
      end
      S_MRG_EV: begin
        if (idx_r == '0) begin
          cur_lo_nxt = rd_lo_r;
          cur_hi_nxt = rd_hi_r;
        end else if (rd_lo_r <= cur_hi_r) begin
          if (rd_lo_r < cur_lo_r) cur_lo_nxt = rd_lo_r;
          if (rd_hi_r > cur_hi_r) cur_hi_nxt = rd_hi_r;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = wp_r[IDX_W-1:0];
          wr_lo      = cur_lo_r;
          wr_hi      = cur_hi_r;
          wp_nxt     = wp_r + CNT_W'(1);
          cur_lo_nxt = rd_lo_r;
          cur_hi_nxt = rd_hi_r;
        end
        idx_nxt   = idx_inc;
        state_nxt = S_MRG_RD;
      end
      S_MRG_END: begin
        wr_en     = 1'b1;
        wr_addr   = wp_r[IDX_W-1:0];
        wr_lo     = cur_lo_r;
        wr_hi     = cur_hi_r;
        cnt_nxt   = wp_r + CNT_W'(1);
        idx_nxt   = '0;
        state_nxt = S_OVR_RD;
      end

      // Remove: move every later entry down by one.
      S_DROP_RD: begin
        if (idx_r == cnt_r) begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          idx_nxt   = '0;
          state_nxt = S_OVR_RD;
        end else begin
          state_nxt = S_DROP_WR;
        end
      end
      S_DROP_WR: begin
        wr_en     = 1'b1;
        wr_addr   = idx_dec[IDX_W-1:0];
        idx_nxt   = idx_inc;
        state_nxt = S_DROP_RD;
      end

      // Rebuild the overall bounds; an empty table reports zero for both.
      S_OVR_RD: begin
        if (idx_r == cnt_r) begin
          min_nxt   = (cnt_r == '0) ? '0 : cur_lo_r;
          max_nxt   = (cnt_r == '0) ? '0 : cur_hi_r;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_OVR_EV;
        end
      end
      S_OVR_EV: begin
        if (idx_r == '0) begin
          cur_lo_nxt = rd_lo_r;
          cur_hi_nxt = rd_hi_r;
        end else begin
          if (rd_lo_r < cur_lo_r) cur_lo_nxt = rd_lo_r;
          if (rd_hi_r > cur_hi_r) cur_hi_nxt = rd_hi_r;
        end
        idx_nxt   = idx_inc;
        state_nxt = S_OVR_RD;
      end

      S_LKP_RD: begin
        if (idx_r == cnt_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_LKP_EV;
        end
      end
      S_LKP_EV: begin
        if (probe_r >= rd_lo_r) begin
          if (!found_r && (probe_r < rd_hi_r)) begin
            found_nxt = 1'b1;
            fidx_nxt  = idx_r[IDX_W-1:0];
          end
          if (probe_r <= rd_hi_r) inside_nxt = 1'b1;
        end
        idx_nxt   = idx_inc;
        state_nxt = S_LKP_RD;
      end

      // The read of the entry was issued in the idle state's cycle.
      S_GET_EV: begin
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    // Read data of a single entry, copied from the memory read register in S_GET_EV.
    if (state_r == S_GET_EV) begin
      elo_nxt = rd_lo_r;
      ehi_nxt = rd_hi_r;
    end
    if (state_r == S_IDLE && in_acc && kind_t'(in_ch.kind) == KIND_READ) begin
      rd_addr = in_ch.position[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      min_r   <= '0;
      max_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      if (out_load) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    probe_r  <= probe_nxt;
    idx_r    <= idx_nxt;
    slot_r   <= slot_nxt;
    wp_r     <= wp_nxt;
    cur_lo_r <= cur_lo_nxt;
    cur_hi_r <= cur_hi_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    fidx_r   <= fidx_nxt;
    inside_r <= inside_nxt;
    cov_r    <= cov_nxt;
    elo_r    <= elo_nxt;
    ehi_r    <= ehi_nxt;
    if (out_load) begin
      o_status_r <= status_r;
      o_found_r  <= found_r;
      o_fidx_r   <= FIDX_W'(fidx_r);
      o_inside_r <= inside_r;
      o_cov_r    <= cov_r;
      o_elo_r    <= elo_r;
      o_ehi_r    <= ehi_r;
      o_cnt_r    <= COUNT_W'(cnt_r);
      o_min_r    <= min_r;
      o_max_r    <= max_r;
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.status        = o_status_r;
  assign out_ch.found         = o_found_r;
  assign out_ch.found_index   = o_fidx_r;
  assign out_ch.inside_any    = o_inside_r;
  assign out_ch.range_covered = o_cov_r;
  assign out_ch.entry_low     = o_elo_r;
  assign out_ch.entry_high    = o_ehi_r;
  assign out_ch.entry_count   = o_cnt_r;
  assign out_ch.overall_low   = o_min_r;
  assign out_ch.overall_high  = o_max_r;

  // The entry count never exceeds the table depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // A full-table answer is only given when the table really is full.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && status_r == ST_FULL) |-> (cnt_r == CNT_W'(DEPTH)))
    else $error("full status with room left");

  // Between items the overall bounds are ordered, and zero when empty.
  a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && cnt_r != '0) |-> (min_r <= max_r))
    else $error("overall bounds out of order");
  a_empty_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && cnt_r == '0) |-> (min_r == '0 && max_r == '0))
    else $error("empty table with nonzero bounds");

  // A clear empties the table at once.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.kind == KIND_CLEAR) |=> (cnt_r == '0))
    else $error("clear did not empty the table");

endmodule

>>> sim/itbl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itbl_checker
// Watches both channels, models the interval table and compares every result.
// ----------------------------------------------------------------------------
module itbl_checker (
  input  logic   clk,
  input  logic   rst_n,
  itbl_in_if     in_ch,
  itbl_out_if    out_ch,
  output int     fail_count,
  output int     pending_count,
  output int     result_count
);
  import itbl_pkg::*;

  localparam int DEPTH = DEPTH_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [FIDX_W-1:0]   found_index;
    logic                inside_any;
    logic                range_covered;
    logic [31:0]         entry_low;
    logic [31:0]         entry_high;
    logic [COUNT_W-1:0]  entry_count;
    logic [31:0]         overall_low;
    logic [31:0]         overall_high;
  } table_result_t;

  logic [31:0]         lo_tab [DEPTH];
  logic [31:0]         hi_tab [DEPTH];
  int                  n_valid;
  logic [31:0]         span_lo, span_hi;
  table_result_t       awaited_results[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void rebuild_span();
    span_lo = 0;
    span_hi = 0;
    for (int i = 0; i < n_valid; i++) begin
      if (i == 0 || lo_tab[i] < span_lo) span_lo = lo_tab[i];
      if (i == 0 || hi_tab[i] > span_hi) span_hi = hi_tab[i];
    end
  endfunction

  function automatic void drop_entry(int at);
    for (int i = at + 1; i < n_valid; i++) begin
      lo_tab[i-1] = lo_tab[i];
      hi_tab[i-1] = hi_tab[i];
    end
    n_valid--;
  endfunction

  // Apply one operation to the shadow table and return what the block owes.
  function automatic table_result_t apply_table_op(kind_t kind, logic [31:0] lo,
      logic [31:0] hi, logic [POS_W-1:0] pos, logic [31:0] probe);
    table_result_t r;
    int slot;
    int i;
    r = '0;
    case (kind)
      KIND_APPEND, KIND_INSERT, KIND_MERGE: begin
        if (lo > hi) r.status = ST_ORDER;
        else if (n_valid >= DEPTH) r.status = ST_FULL;
        else begin
          slot = n_valid;
          if (kind != KIND_APPEND) begin
            slot = 0;
            while (slot < n_valid && !(lo < lo_tab[slot])) slot++;
          end
          for (i = n_valid; i > slot; i--) begin
            lo_tab[i] = lo_tab[i-1];
            hi_tab[i] = hi_tab[i-1];
          end
          lo_tab[slot] = lo;
          hi_tab[slot] = hi;
          n_valid++;
          if (kind == KIND_MERGE) begin
            i = 0;
            while (n_valid > 1 && i < n_valid - 1) begin
              if (lo_tab[i+1] <= hi_tab[i]) begin
                if (lo_tab[i+1] < lo_tab[i]) lo_tab[i] = lo_tab[i+1];
                if (hi_tab[i+1] > hi_tab[i]) hi_tab[i] = hi_tab[i+1];
                drop_entry(i + 1);
              end else i++;
            end
          end
          rebuild_span();
        end
      end
      KIND_REMOVE: begin
        if (pos >= n_valid) r.status = ST_BAD_POS;
        else begin
          drop_entry(pos);
          rebuild_span();
        end
      end
      KIND_LOOKUP: begin
        for (i = n_valid - 1; i >= 0; i--) begin
          if (probe >= lo_tab[i] && probe < hi_tab[i]) begin
            r.found = 1'b1;
            r.found_index = i[FIDX_W-1:0];
          end
          if (probe >= lo_tab[i] && probe <= hi_tab[i]) r.inside_any = 1'b1;
        end
      end
      KIND_RANGE: r.range_covered = (lo >= span_lo && hi <= span_hi);
      KIND_READ: begin
        if (pos >= n_valid) r.status = ST_BAD_POS;
        else begin
          r.entry_low = lo_tab[pos];
          r.entry_high = hi_tab[pos];
        end
      end
      default: begin
        n_valid = 0;
        rebuild_span();
      end
    endcase
    r.entry_count = n_valid[COUNT_W-1:0];
    r.overall_low = span_lo;
    r.overall_high = span_hi;
    return r;
  endfunction

  assign pending_count = awaited_results.size();

  always @(posedge clk) begin
    table_result_t want;
    if (!rst_n) begin
      n_valid = 0;
      span_lo = 0;
      span_hi = 0;
      awaited_results.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      // The result side is checked first: the block cannot answer an item in
      // the same edge that it accepts it.
      if (out_ch.valid && out_ch.ready) begin
        result_count++;
        if (awaited_results.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch("status", out_ch.status, want.status);
          if (out_ch.found !== want.found)
            report_mismatch("found", out_ch.found, want.found);
          if (out_ch.found_index !== want.found_index)
            report_mismatch("found_index", out_ch.found_index, want.found_index);
          if (out_ch.inside_any !== want.inside_any)
            report_mismatch("inside_any", out_ch.inside_any, want.inside_any);
          if (out_ch.range_covered !== want.range_covered)
            report_mismatch("range_covered", out_ch.range_covered, want.range_covered);
          if (out_ch.entry_low !== want.entry_low)
            report_mismatch("entry_low", out_ch.entry_low, want.entry_low);
          if (out_ch.entry_high !== want.entry_high)
            report_mismatch("entry_high", out_ch.entry_high, want.entry_high);
          if (out_ch.entry_count !== want.entry_count)
            report_mismatch("entry_count", out_ch.entry_count, want.entry_count);
          if (out_ch.overall_low !== want.overall_low)
            report_mismatch("overall_low", out_ch.overall_low, want.overall_low);
          if (out_ch.overall_high !== want.overall_high)
            report_mismatch("overall_high", out_ch.overall_high, want.overall_high);
        end
      end
      if (in_ch.valid && in_ch.ready)
        awaited_results.push_back(apply_table_op(kind_t'(in_ch.kind), in_ch.low_energy,
            in_ch.high_energy, in_ch.position, in_ch.probe_energy));
    end
  end

endmodule

>>> sim/interval_table_engine_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_table_engine_top_tb
// Drives table operations into the interval table engine and judges the run.
// ----------------------------------------------------------------------------
// A short directed sequence hits the boundaries first: empty-table reads and
// removes, order errors, a full table, touching merges and edge probes. The
// random part then mostly builds small tables with realistic values,
// probes and reads them, and clears them from time to time. A separate checker
// predicts every result; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module interval_table_engine_top_tb;
  import itbl_pkg::*;

  localparam int RANDOM_ITEMS = 1830;
  // Worst item is a full merge plus stalls on both sides.
  localparam int STALL_LIMIT  = 5000;

  logic clk;
  logic rst_n;
  int   fail_count, pending_count, result_count;
  int   idle_cycles;
  bit   calm_phase;
  bit   timed_out;
  int   ops_seen [8];
  logic [31:0] recent_low [$];

  itbl_in_if  in_ch ();
  itbl_out_if out_ch ();

  interval_table_engine_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  itbl_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: any cycle without a handshake on either channel counts up.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired with %0d results outstanding", pending_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The result side stalls in bursts until the final, calm stretch of the run.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Present one item and hold it until the block takes it. Valid stays high
  // between back-to-back items, so it is never dropped and raised in one step.
  task automatic send_op(input kind_t kind, input logic [31:0] lo, input logic [31:0] hi,
                         input logic [POS_W-1:0] pos, input logic [31:0] probe);
    if (!calm_phase && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.low_energy   <= lo;
    in_ch.high_energy  <= hi;
    in_ch.position     <= pos;
    in_ch.probe_energy <= probe;
    ops_seen[kind]++;
    if (kind <= KIND_MERGE) recent_low.push_back(lo);
    if (recent_low.size() > 8) void'(recent_low.pop_front());
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // A 16.16 value that is mostly in a narrow band, so intervals overlap often.
  function automatic logic [31:0] pick_energy();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 3);
      3: return (recent_low.size() != 0) ? recent_low[$urandom_range(0, recent_low.size()-1)]
                                         : 32'h0001_0000;
      default: return $urandom_range(0, 64) << 14;
    endcase
  endfunction

  task automatic send_random_op(input int table_fill);
    logic [31:0] a, b;
    int roll;
    kind_t kind;
    a = pick_energy();
    b = ($urandom_range(0, 9) == 0) ? pick_energy() : a + $urandom_range(0, 8) * 32'h4000;
    if (b < a && $urandom_range(0, 3) != 0) b = 32'hFFFF_FFFF;
    roll = $urandom_range(0, 99);
    if (roll < 45) kind = kind_t'($urandom_range(0, 2));
    else if (roll < 53) kind = KIND_REMOVE;
    else if (roll < 73) kind = KIND_LOOKUP;
    else if (roll < 81) kind = KIND_RANGE;
    else if (roll < 95) kind = KIND_READ;
    else kind = KIND_CLEAR;
    // Clearing is kept rarer once the table is small so that it fills up.
    if (kind == KIND_CLEAR && table_fill < 6 && $urandom_range(0, 2) != 0) kind = KIND_LOOKUP;
    send_op(kind, a, b,
            POS_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                   : $urandom_range(0, (table_fill > 0) ? table_fill : 1)),
            ($urandom_range(0, 2) == 0) ? a : pick_energy());
  endtask

  initial begin
    int fill;
    timed_out = 1'b0;
    calm_phase = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_CLEAR;
    in_ch.low_energy = '0;
    in_ch.high_energy = '0;
    in_ch.position = '0;
    in_ch.probe_energy = '0;
    foreach (ops_seen[i]) ops_seen[i] = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: empty table, order error, touching merge, full table.
    send_op(KIND_READ, 0, 0, 0, 0);
    send_op(KIND_REMOVE, 0, 0, 4'hF, 0);
    send_op(KIND_LOOKUP, 0, 0, 0, 0);
    send_op(KIND_RANGE, 0, 0, 0, 0);
    send_op(KIND_RANGE, 32'hFFFF_FFFF, 32'h0, 0, 0);
    send_op(KIND_APPEND, 32'h0002_0000, 32'h0001_0000, 0, 0);
    send_op(KIND_INSERT, 32'h0003_0000, 32'h0004_0000, 0, 0);
    send_op(KIND_INSERT, 32'h0001_0000, 32'h0002_0000, 0, 0);
    send_op(KIND_MERGE, 32'h0002_0000, 32'h0003_0000, 0, 0);
    send_op(KIND_LOOKUP, 0, 0, 0, 32'h0004_0000);
    send_op(KIND_LOOKUP, 0, 0, 0, 32'h0001_0000);
    send_op(KIND_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    send_op(KIND_APPEND, 32'h0, 32'h0, 0, 0);
    send_op(KIND_LOOKUP, 0, 0, 0, 32'hFFFF_FFFF);
    send_op(KIND_READ, 0, 0, 4'd2, 0);
    send_op(KIND_RANGE, 32'h0, 32'hFFFF_FFFF, 0, 0);
    send_op(KIND_REMOVE, 0, 0, 4'd0, 0);
    for (int i = 0; i < 15; i++)
      send_op(KIND_APPEND, i << 17, (i << 17) + 32'h0001_0000, 0, 0);
    send_op(KIND_MERGE, 32'h5, 32'h6, 0, 0);
    send_op(KIND_READ, 0, 0, 4'd15, 0);
    send_op(KIND_REMOVE, 0, 0, 4'd15, 0);
    send_op(KIND_MERGE, 32'h0, 32'hFFFF_FFFF, 0, 0);
    send_op(KIND_CLEAR, 0, 0, 0, 0);

    // Random part; the fill estimate only steers positions and clears.
    fill = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - 200) calm_phase = 1'b1;
      send_random_op(fill);
      fill = (in_ch.kind == KIND_CLEAR) ? 0 :
             (in_ch.kind <= KIND_MERGE && fill < 16) ? fill + 1 :
             (in_ch.kind == KIND_REMOVE && fill > 0) ? fill - 1 : fill;
    end
    in_ch.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d items and %0d results: append %0d insert %0d merge %0d remove %0d",
             ops_seen.sum(), result_count, ops_seen[0], ops_seen[1], ops_seen[2], ops_seen[3]);
    $display("  lookup %0d range %0d read %0d clear %0d", ops_seen[4], ops_seen[5],
             ops_seen[6], ops_seen[7]);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
